FILE: rtl/mctt_pkg.sv
`timescale 1ns / 1ps

package mctt_pkg;

	localparam int unsigned HANDLE_W = 31;
	localparam int unsigned PERIOD_W = 24;
	localparam int unsigned RUNS_W = 17;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned RESULT_CAP = 16;
	localparam logic [HANDLE_W-1:0] FIRST_HANDLE = 31'd100;
	localparam logic signed [RUNS_W-1:0] REPEAT_FOREVER = -17'sd1;

	// Command codes.
	typedef enum logic [2:0] {
		FUNC_TICK = 3'd0,
		FUNC_START = 3'd1,
		FUNC_STOP = 3'd2,
		FUNC_COUNT = 3'd3,
		FUNC_ELAPSED = 3'd4,
		FUNC_REMAIN = 3'd5,
		FUNC_RESTART = 3'd6,
		FUNC_BAD = 3'd7
	} func_t;

	// Status codes.
	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	// Command queued between front and back.
	typedef struct packed {
		func_t func;
		logic [HANDLE_W-1:0] timer_handle;
		logic signed [RUNS_W-1:0] run_count;
		logic [PERIOD_W-1:0] interval_ms;
	} cmd_t;

	// Queue status toward the front.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Back engine states.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_EXEC,
		BK_PICK,
		BK_FIRE
	} bk_state_t;

endpackage

FILE: rtl/mctt_queue.sv
`timescale 1ns / 1ps

module mctt_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mctt_pkg::cmd_t push_cmd,
	input logic pop,
	output mctt_pkg::cmd_t head,
	output mctt_pkg::qstat_t stat
);

	// Two-entry queue of commands.
	mctt_pkg::cmd_t buf_q [2];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head = buf_q[rptr_q];
	assign stat.full = cnt_q[1];
	assign stat.empty = (cnt_q == 2'd0);

endmodule

FILE: rtl/mctt_front.sv
`timescale 1ns / 1ps

module mctt_front (
	input logic start,
	input logic [2:0] func,
	input logic [30:0] timer_handle,
	input logic signed [16:0] run_count,
	input logic [23:0] interval_ms,
	input mctt_pkg::qstat_t stat,
	output logic busy,
	output logic push,
	output mctt_pkg::cmd_t push_cmd
);

	// Accept a beat whenever the queue has room and classify the code.
	assign busy = stat.full;
	assign push = start && !stat.full;

	// Every 3-bit code maps onto a command; code 7 is the unknown command.
	always_comb begin
		push_cmd.timer_handle = timer_handle;
		push_cmd.run_count = run_count;
		push_cmd.interval_ms = interval_ms;
		push_cmd.func = mctt_pkg::func_t'(func);
	end

endmodule

FILE: rtl/mctt_back.sv
`timescale 1ns / 1ps

module mctt_back #(
	parameter int unsigned MAX_TIMERS = 16
) (
	input logic clk,
	input logic arst_n,
	input mctt_pkg::cmd_t head,
	input mctt_pkg::qstat_t stat,
	output logic pop,
	output logic strobe,
	output logic [1:0] status,
	output logic [30:0] out_handle,
	output logic [31:0] value,
	output logic fired,
	output logic last
);

	localparam int unsigned IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_TIMERS + 1);
	localparam int unsigned FC_W = $clog2(mctt_pkg::RESULT_CAP + 1);

	// Slot table, one flop row per slot.
	logic [MAX_TIMERS-1:0] valid_q;
	logic [MAX_TIMERS-1:0] due_q;
	logic [30:0] hnd_q [MAX_TIMERS];
	logic [23:0] per_q [MAX_TIMERS];
	logic signed [16:0] runs_q [MAX_TIMERS];
	logic [31:0] st_q [MAX_TIMERS];
	logic [31:0] end_q [MAX_TIMERS];

	logic [31:0] now_q;
	logic [30:0] next_h_q;
	logic [CNT_W-1:0] active_q;

	mctt_pkg::bk_state_t state_q, state_d;
	mctt_pkg::cmd_t cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] step_q;
	logic hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [FC_W-1:0] nfire_q;

	logic scan_last;
	logic [30:0] hcur;
	logic due_cur;
	logic [31:0] el_cur;
	logic [FC_W-1:0] nfire_nx;
	logic out_v;

	assign scan_last = (step_q == CNT_W'(MAX_TIMERS - 1));
	assign hcur = hnd_q[idx_q];
	assign el_cur = now_q - st_q[idx_q];
	assign nfire_nx = nfire_q + FC_W'(1);

	// Due test on the slot under the scan pointer, against the advanced time.
	always_comb begin
		if (runs_q[idx_q] > 17'sd0) begin
			due_cur = (now_q >= end_q[idx_q]);
		end else if (runs_q[idx_q] == mctt_pkg::REPEAT_FOREVER) begin
			due_cur = (el_cur >= {8'd0, per_q[idx_q]});
		end else begin
			due_cur = 1'b0;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mctt_pkg::BK_IDLE: if (!stat.empty) state_d = mctt_pkg::BK_SCAN;
			mctt_pkg::BK_SCAN: if (scan_last) begin
				state_d = (cmd_q.func == mctt_pkg::FUNC_TICK) ?
					mctt_pkg::BK_PICK : mctt_pkg::BK_EXEC;
			end
			mctt_pkg::BK_EXEC: state_d = mctt_pkg::BK_IDLE;
			mctt_pkg::BK_PICK: if (scan_last) state_d = mctt_pkg::BK_FIRE;
			mctt_pkg::BK_FIRE: begin
				if (!best_q || nfire_nx == FC_W'(mctt_pkg::RESULT_CAP))
					state_d = mctt_pkg::BK_IDLE;
				else
					state_d = mctt_pkg::BK_PICK;
			end
			default: state_d = mctt_pkg::BK_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		pop = (state_q == mctt_pkg::BK_IDLE) && !stat.empty;
		out_v = (state_q == mctt_pkg::BK_EXEC) ||
			((state_q == mctt_pkg::BK_FIRE) && (best_q || nfire_q == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mctt_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan, command execution and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			now_q <= '0;
			next_h_q <= mctt_pkg::FIRST_HANDLE;
			active_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= out_v;
			case (state_q)
				mctt_pkg::BK_IDLE: if (!stat.empty) begin
					cmd_q <= head;
					idx_q <= '0;
					step_q <= '0;
					hit_q <= 1'b0;
					free_q <= 1'b0;
					nfire_q <= '0;
					if (head.func == mctt_pkg::FUNC_TICK) now_q <= now_q + 32'd1;
				end
				mctt_pkg::BK_SCAN: begin
					if (!valid_q[idx_q] && !free_q) begin
						free_q <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (valid_q[idx_q] && !hit_q && hcur == cmd_q.timer_handle) begin
						hit_q <= 1'b1;
						hit_idx_q <= idx_q;
					end
					due_q[idx_q] <= valid_q[idx_q] && due_cur;
					best_q <= 1'b0;
					idx_q <= scan_last ? '0 : idx_q + IDX_W'(1);
					step_q <= scan_last ? '0 : step_q + CNT_W'(1);
				end
				mctt_pkg::BK_EXEC: begin
					status <= mctt_pkg::ST_OK;
					out_handle <= '0;
					value <= '0;
					fired <= 1'b0;
					last <= 1'b1;
					case (cmd_q.func)
						mctt_pkg::FUNC_START: begin
							if (!free_q) begin
								status <= mctt_pkg::ST_FULL;
							end else begin
								valid_q[free_idx_q] <= 1'b1;
								hnd_q[free_idx_q] <= next_h_q;
								per_q[free_idx_q] <= cmd_q.interval_ms;
								runs_q[free_idx_q] <= cmd_q.run_count;
								st_q[free_idx_q] <= now_q;
								end_q[free_idx_q] <= now_q + {8'd0, cmd_q.interval_ms};
								next_h_q <= next_h_q + 31'd1;
								active_q <= active_q + CNT_W'(1);
								out_handle <= next_h_q;
							end
						end
						mctt_pkg::FUNC_COUNT: value <= 32'(active_q);
						mctt_pkg::FUNC_BAD: status <= mctt_pkg::ST_UNKNOWN;
						default: begin
							if (!hit_q) begin
								status <= mctt_pkg::ST_NOT_FOUND;
							end else if (cmd_q.func == mctt_pkg::FUNC_STOP) begin
								valid_q[hit_idx_q] <= 1'b0;
								active_q <= active_q - CNT_W'(1);
							end else if (cmd_q.func == mctt_pkg::FUNC_ELAPSED) begin
								value <= now_q - st_q[hit_idx_q];
							end else if (cmd_q.func == mctt_pkg::FUNC_REMAIN) begin
								value <= end_q[hit_idx_q] - now_q;
							end else if (now_q != '0) begin
								st_q[hit_idx_q] <= now_q;
								end_q[hit_idx_q] <= now_q + {8'd0, per_q[hit_idx_q]};
							end
						end
					endcase
				end
				mctt_pkg::BK_PICK: begin
					// Lowest handle among due slots; ties keep the lower slot.
					if (due_q[idx_q] && (!best_q || hcur < hnd_q[best_idx_q])) begin
						best_q <= 1'b1;
						best_idx_q <= idx_q;
					end
					idx_q <= scan_last ? '0 : idx_q + IDX_W'(1);
					step_q <= scan_last ? '0 : step_q + CNT_W'(1);
				end
				mctt_pkg::BK_FIRE: begin
					status <= mctt_pkg::ST_OK;
					value <= '0;
					if (best_q) begin
						out_handle <= hnd_q[best_idx_q];
						fired <= 1'b1;
						last <= (nfire_nx == FC_W'(mctt_pkg::RESULT_CAP)) ||
							($countones(due_q) == 1);
						due_q[best_idx_q] <= 1'b0;
						nfire_q <= nfire_nx;
						st_q[best_idx_q] <= now_q;
						end_q[best_idx_q] <= now_q + {8'd0, per_q[best_idx_q]};
						if (runs_q[best_idx_q] > 17'sd0) begin
							runs_q[best_idx_q] <= runs_q[best_idx_q] - 17'sd1;
							if (runs_q[best_idx_q] == 17'sd1) begin
								valid_q[best_idx_q] <= 1'b0;
								active_q <= active_q - CNT_W'(1);
							end
						end
					end else begin
						out_handle <= '0;
						fired <= 1'b0;
						last <= 1'b1;
					end
					best_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/multi_channel_timer_table_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Fields
// command   in         start / busy       func, timer_handle, run_count, interval_ms
// result    out        strobe, no stall   status, out_handle, value, fired, last
//
// A beat enters a two-deep queue and the back engine scans all MAX_TIMERS slots once
// before a non-tick result is given. A tick adds a handle-order pick pass before its
// first result and one before each further fired timer, and one more pass follows
// unless 16 fired.
// arst_n clears the table valid bits, time and control and resets the handle counter to 100.
// busy is high while the queue is full; results cannot be stalled.

module multi_channel_timer_table_top #(
	parameter int unsigned MAX_TIMERS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] func,
	input logic [30:0] timer_handle,
	input logic signed [16:0] run_count,
	input logic [23:0] interval_ms,
	output logic strobe,
	output logic [1:0] status,
	output logic [30:0] out_handle,
	output logic [31:0] value,
	output logic fired,
	output logic last
);

	mctt_pkg::qstat_t stat;
	mctt_pkg::cmd_t push_cmd;
	mctt_pkg::cmd_t head;
	logic push;
	logic pop;

	// Front end: accept and classify.
	mctt_front u_front (
		.start(start), .func(func), .timer_handle(timer_handle),
		.run_count(run_count), .interval_ms(interval_ms), .stat(stat),
		.busy(busy), .push(push), .push_cmd(push_cmd)
	);

	// Decoupling queue.
	mctt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(push_cmd),
		.pop(pop), .head(head), .stat(stat)
	);

	// Back end: slot table engine.
	mctt_back #(.MAX_TIMERS(MAX_TIMERS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .stat(stat), .pop(pop),
		.strobe(strobe), .status(status), .out_handle(out_handle),
		.value(value), .fired(fired), .last(last)
	);

endmodule

FILE: rtl/mctt_checker.sv
`timescale 1ns / 1ps

module mctt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic [1:0] status,
	input logic [30:0] out_handle,
	input logic fired,
	input logic last
);

	// A fired report is always an ok beat with a handle.
	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && fired |-> status == mctt_pkg::ST_OK && out_handle != 31'd0)
		else $error("fired beat malformed");

	// Results never come back to back: each comes out of a scan.
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("results adjacent");

	// A beat that does not fire always ends its item.
	a_nofire_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !fired |-> last)
		else $error("non-fire beat not last");

	// A full queue drains within the longest tick the engine can run.
	a_busy_release: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> ##[1:512] !busy)
		else $error("busy held too long");

endmodule

bind multi_channel_timer_table_top mctt_checker u_mctt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.status(status), .out_handle(out_handle), .fired(fired), .last(last)
);
